FILE: design/aba_dcd_pkg.sv
// shared types and default sizes for the drift-corrected aba difference block
`default_nettype none

package aba_dcd_pkg;

  // default field sizes
  localparam int TIME_BITS_DEF  = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_DIV_WP,
    ST_MUL,
    ST_SQRT,
    ST_DONE
  } state_t;

  // products taken in turn on the serial multiplier
  typedef enum logic [3:0] {
    OP_EB2,
    OP_EA2SQ,
    OP_EA1SQ,
    OP_WDF,
    OP_WPDP,
    OP_WWP,
    OP_U2,
    OP_U1,
    OP_U2SQ,
    OP_U1SQ,
    OP_BT
  } mul_op_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

FILE: design/aba_drift_corrected_difference.sv
// top level: drift-corrected aba difference with serial divide, multiply and root
// plain mode: three products on the serial multiplier, then the square root; time-weighted
//   mode: two weight divisions, nine products and the root; a zero interval skips them all
// each serial step is started by the sequencer and ends when its unit signals done
// one trial at a time, the next accepted once the result is offered; series starts only store
// reset (rst_n low, synchronous): no stored trial, plain mode, output channel empty
`default_nettype none

module aba_drift_corrected_difference #(
  parameter int TIME_BITS  = aba_dcd_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = aba_dcd_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = aba_dcd_pkg::FRAC_BITS_DEF,
  localparam int IN_BITS   = ((2*TIME_BITS + 4*VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = ((2*VALUE_BITS + 7) / 8) * 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // fields from bit 0: a_time, a_value, a_error, b_time, b_value, b_error
  input  wire  [IN_BITS-1:0]  in_tdata,
  // fields from bit 0: start_series
  input  wire  [0:0]          in_tuser,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // fields from bit 0: difference, difference_error
  output logic [OUT_BITS-1:0] out_tdata,
  // fields from bit 0: status
  output logic [1:0]          out_tuser,
  output logic                out_tvalid,
  input  wire                 out_tready,
  // use_time_weight
  input  wire  [0:0]          cfg_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready
);

  localparam int T  = TIME_BITS;
  localparam int V  = VALUE_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MB = (V > F + 1) ? V : F + 1;
  localparam int MA = 2 * V;
  localparam int PW = MA + MB;
  localparam int RW = V + 2;
  localparam int SW = 2 * RW;
  localparam int WB = F + 1;
  localparam int DW = V + 1;
  localparam int PP = WB + DW;
  localparam logic [F+2:0] ONE_C = (F+3)'(1) << F;

  typedef struct packed {
    logic         sat;
    logic [V-1:0] val;
  } sdiff_t;

  // |a - b| of two time stamps
  function automatic logic [T-1:0] tdist(input logic [T-1:0] a, input logic [T-1:0] b);
    logic [T:0] df;
    df = {1'b0, a} - {1'b0, b};
    return df[T] ? T'(~df + (T+1)'(1)) : df[T-1:0];
  endfunction

  // clamp a signed magnitude to the signed value range
  function automatic sdiff_t sat_diff(input logic neg, input logic [V+2:0] m);
    logic [V+2:0] limit, v;
    sdiff_t       r;
    limit = neg ? ((V+3)'(1) << (V-1)) : (((V+3)'(1) << (V-1)) - (V+3)'(1));
    r.sat = (m > limit);
    v     = r.sat ? limit : m;
    r.val = neg ? (~v[V-1:0] + V'(1)) : v[V-1:0];
    return r;
  endfunction

  // registers
  aba_dcd_pkg::state_t  state_r, state_nxt;
  aba_dcd_pkg::mul_op_t mop_r, mop_nxt;
  logic                 use_tw_r, have_prev_r;
  logic [T-1:0]         prev_a_time_r, prev_b_time_r, cur_a_time_r, cur_b_time_r;
  logic [V-1:0]         prev_a_value_r, prev_b_value_r, cur_a_value_r, cur_b_value_r;
  logic [V-1:0]         prev_a_error_r, prev_b_error_r, cur_a_error_r, cur_b_error_r;
  logic                 zero_r, sat_r, cneg_r;
  logic [V-1:0]         dval_r, u2_r, u1_r;
  logic [2*V-1:0]       eb2_r;
  logic [SW-1:0]        s_r;
  logic [PP-1:0]        p1_r;
  logic [WB-1:0]        w_r, wp_r, cmag_r;
  logic                 out_valid_r;
  logic [2*V-1:0]       out_data_r;
  logic [1:0]           out_status_r;

  // input fields
  logic [T-1:0] in_a_time, in_b_time;
  logic [V-1:0] in_a_value, in_a_error, in_b_value, in_b_error;
  logic         in_start, new_series, in_zero, accept;

  assign in_a_time  = in_tdata[T-1:0];
  assign in_a_value = in_tdata[T+V-1:T];
  assign in_a_error = in_tdata[T+2*V-1:T+V];
  assign in_b_time  = in_tdata[2*T+2*V-1:T+2*V];
  assign in_b_value = in_tdata[2*T+3*V-1:2*T+2*V];
  assign in_b_error = in_tdata[2*T+4*V-1:2*T+3*V];
  assign in_start   = in_tuser[0];
  assign accept     = in_tvalid && in_tready;
  assign new_series = in_start || !have_prev_r;
  assign in_zero    = (tdist(in_a_time, prev_a_time_r) == '0);

  // plain mode difference from the incoming trial
  logic [V+2:0] psum, pmag;
  sdiff_t       pdiff;
  always_comb begin
    psum  = (V+3)'(signed'(prev_a_value_r)) + (V+3)'(signed'(in_a_value))
            - ((V+3)'(signed'(prev_b_value_r)) << 1);
    pmag  = psum[V+2] ? (~psum + (V+3)'(1)) : psum;
    pdiff = sat_diff(psum[V+2], pmag >> 1);
  end

  // serial units
  aba_dcd_pkg::unit_stat_t div_stat, mul_stat, sqrt_stat;
  logic                    div_start, mul_start, sqrt_start;
  logic [T-1:0]            div_x, div_d;
  logic [WB-1:0]           div_q;
  logic [MA-1:0]           mul_a;
  logic [MB-1:0]           mul_b;
  logic [PW-1:0]           prod;
  logic [RW-1:0]           root;

  assign div_d = tdist(cur_a_time_r, prev_a_time_r);
  assign div_x = (state_r == aba_dcd_pkg::ST_DIV_W) ? tdist(prev_a_time_r, prev_b_time_r)
                                                     : tdist(cur_a_time_r, prev_b_time_r);

  aba_dcd_div #(.T_BITS(T), .F_BITS(F)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .x(div_x), .d(div_d),
    .stat(div_stat), .q(div_q)
  );

  aba_dcd_mul #(.A_BITS(MA), .B_BITS(MB)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .stat(mul_stat), .prod(prod)
  );

  aba_dcd_sqrt #(.R_BITS(RW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .rad(s_r),
    .stat(sqrt_stat), .root(root)
  );

  // value differences against the stored b
  logic [V:0]  df, dp;
  logic [DW-1:0] df_mag, dp_mag;
  always_comb begin
    df     = {cur_a_value_r[V-1], cur_a_value_r} - {prev_b_value_r[V-1], prev_b_value_r};
    dp     = {prev_a_value_r[V-1], prev_a_value_r} - {prev_b_value_r[V-1], prev_b_value_r};
    df_mag = df[V] ? (~df + DW'(1)) : df;
    dp_mag = dp[V] ? (~dp + DW'(1)) : dp;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mop_r)
      aba_dcd_pkg::OP_EB2:   begin mul_a = MA'(prev_b_error_r); mul_b = MB'(prev_b_error_r); end
      aba_dcd_pkg::OP_EA2SQ: begin mul_a = MA'(cur_a_error_r);  mul_b = MB'(cur_a_error_r);  end
      aba_dcd_pkg::OP_EA1SQ: begin mul_a = MA'(prev_a_error_r); mul_b = MB'(prev_a_error_r); end
      aba_dcd_pkg::OP_WDF:   begin mul_a = MA'(df_mag);         mul_b = MB'(w_r);            end
      aba_dcd_pkg::OP_WPDP:  begin mul_a = MA'(dp_mag);         mul_b = MB'(wp_r);           end
      aba_dcd_pkg::OP_WWP:   begin mul_a = MA'(w_r);            mul_b = MB'(wp_r);           end
      aba_dcd_pkg::OP_U2:    begin mul_a = MA'(cur_a_error_r);  mul_b = MB'(w_r);            end
      aba_dcd_pkg::OP_U1:    begin mul_a = MA'(prev_a_error_r); mul_b = MB'(wp_r);           end
      aba_dcd_pkg::OP_U2SQ:  begin mul_a = MA'(u2_r);           mul_b = MB'(u2_r);           end
      aba_dcd_pkg::OP_U1SQ:  begin mul_a = MA'(u1_r);           mul_b = MB'(u1_r);           end
      aba_dcd_pkg::OP_BT:    begin mul_a = eb2_r;               mul_b = MB'(cmag_r);         end
      default:               begin mul_a = '0;                  mul_b = '0;                  end
    endcase
  end

  // product order
  logic last_op;
  always_comb begin
    case (mop_r)
      aba_dcd_pkg::OP_EB2:   mop_nxt = use_tw_r ? aba_dcd_pkg::OP_WDF : aba_dcd_pkg::OP_EA2SQ;
      aba_dcd_pkg::OP_EA2SQ: mop_nxt = aba_dcd_pkg::OP_EA1SQ;
      aba_dcd_pkg::OP_WDF:   mop_nxt = aba_dcd_pkg::OP_WPDP;
      aba_dcd_pkg::OP_WPDP:  mop_nxt = aba_dcd_pkg::OP_WWP;
      aba_dcd_pkg::OP_WWP:   mop_nxt = aba_dcd_pkg::OP_U2;
      aba_dcd_pkg::OP_U2:    mop_nxt = aba_dcd_pkg::OP_U1;
      aba_dcd_pkg::OP_U1:    mop_nxt = aba_dcd_pkg::OP_U2SQ;
      aba_dcd_pkg::OP_U2SQ:  mop_nxt = aba_dcd_pkg::OP_U1SQ;
      aba_dcd_pkg::OP_U1SQ:  mop_nxt = aba_dcd_pkg::OP_BT;
      default:               mop_nxt = aba_dcd_pkg::OP_EB2;
    endcase
    last_op = use_tw_r ? (mop_r == aba_dcd_pkg::OP_BT) : (mop_r == aba_dcd_pkg::OP_EA1SQ);
  end

  // weighted difference and correlation factor from the products
  logic [PP-1:0]  p2;
  logic [PP:0]    wm;
  logic           wneg;
  sdiff_t         wdiff;
  logic [F+2:0]   twop;
  logic           cneg;
  logic [F+2:0]   cval;
  logic [2*V-1:0] bt;
  logic [SW-1:0]  bt_ext;
  always_comb begin
    p2 = prod[PP-1:0];
    if (df[V] == dp[V]) begin
      wm   = {1'b0, p1_r} + {1'b0, p2};
      wneg = df[V];
    end else if (p1_r >= p2) begin
      wm   = {1'b0, p1_r} - {1'b0, p2};
      wneg = df[V];
    end else begin
      wm   = {1'b0, p2} - {1'b0, p1_r};
      wneg = dp[V];
    end
    wdiff  = sat_diff(wneg, wm[PP:F]);
    twop   = prod[2*F+1:F-1];
    cneg   = (twop > ONE_C);
    cval   = cneg ? (twop - ONE_C) : (ONE_C - twop);
    bt     = prod[2*V+F-1:F];
    bt_ext = SW'(bt);
  end

  // final error and status
  logic [RW-1:0]  e_full;
  logic           esat;
  logic [V-1:0]   e_val;
  logic [1:0]     status_c;
  always_comb begin
    e_full = use_tw_r ? root : (root >> 1);
    esat   = (e_full[RW-1:V] != '0);
    e_val  = esat ? {V{1'b1}} : e_full[V-1:0];
    if (zero_r)
      status_c = aba_dcd_pkg::STATUS_ZERO;
    else if (sat_r || esat)
      status_c = aba_dcd_pkg::STATUS_SAT;
    else
      status_c = aba_dcd_pkg::STATUS_OK;
  end

  // next state
  logic out_free;
  assign out_free = !out_valid_r || out_tready;
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aba_dcd_pkg::ST_IDLE: begin
        if (in_tvalid && !new_series) begin
          if (!use_tw_r)
            state_nxt = aba_dcd_pkg::ST_MUL;
          else if (in_zero)
            state_nxt = aba_dcd_pkg::ST_DONE;
          else
            state_nxt = aba_dcd_pkg::ST_DIV_W;
        end
      end
      aba_dcd_pkg::ST_DIV_W: begin
        if (div_stat.done) state_nxt = aba_dcd_pkg::ST_DIV_WP;
      end
      aba_dcd_pkg::ST_DIV_WP: begin
        if (div_stat.done) state_nxt = aba_dcd_pkg::ST_MUL;
      end
      aba_dcd_pkg::ST_MUL: begin
        if (mul_stat.done && last_op) state_nxt = aba_dcd_pkg::ST_SQRT;
      end
      aba_dcd_pkg::ST_SQRT: begin
        if (sqrt_stat.done) state_nxt = aba_dcd_pkg::ST_DONE;
      end
      aba_dcd_pkg::ST_DONE: begin
        if (zero_r || out_free) begin
          if (out_free) state_nxt = aba_dcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aba_dcd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = (state_r == aba_dcd_pkg::ST_IDLE);
    div_start  = ((state_r == aba_dcd_pkg::ST_DIV_W) || (state_r == aba_dcd_pkg::ST_DIV_WP))
                 && !div_stat.busy && !div_stat.done;
    mul_start  = (state_r == aba_dcd_pkg::ST_MUL) && !mul_stat.busy && !mul_stat.done;
    sqrt_start = (state_r == aba_dcd_pkg::ST_SQRT) && !sqrt_stat.busy && !sqrt_stat.done;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aba_dcd_pkg::ST_IDLE;
      mop_r       <= aba_dcd_pkg::OP_EB2;
      use_tw_r    <= 1'b0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready)
        use_tw_r <= cfg_data[0];
      if (accept)
        have_prev_r <= 1'b1;
      if (state_r == aba_dcd_pkg::ST_IDLE)
        mop_r <= aba_dcd_pkg::OP_EB2;
      else if ((state_r == aba_dcd_pkg::ST_MUL) && mul_stat.done && !last_op)
        mop_r <= mop_nxt;
      if ((state_r == aba_dcd_pkg::ST_DONE) && out_free)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  // stored trials
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_time_r  <= '0;
      prev_a_value_r <= '0;
      prev_a_error_r <= '0;
      prev_b_time_r  <= '0;
      prev_b_value_r <= '0;
      prev_b_error_r <= '0;
    end else if (accept && new_series) begin
      prev_a_time_r  <= in_a_time;
      prev_a_value_r <= in_a_value;
      prev_a_error_r <= in_a_error;
      prev_b_time_r  <= in_b_time;
      prev_b_value_r <= in_b_value;
      prev_b_error_r <= in_b_error;
    end else if ((state_r == aba_dcd_pkg::ST_DONE) && out_free) begin
      prev_a_time_r  <= cur_a_time_r;
      prev_a_value_r <= cur_a_value_r;
      prev_a_error_r <= cur_a_error_r;
      prev_b_time_r  <= cur_b_time_r;
      prev_b_value_r <= cur_b_value_r;
      prev_b_error_r <= cur_b_error_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_a_time_r  <= in_a_time;
      cur_a_value_r <= in_a_value;
      cur_a_error_r <= in_a_error;
      cur_b_time_r  <= in_b_time;
      cur_b_value_r <= in_b_value;
      cur_b_error_r <= in_b_error;
      zero_r        <= use_tw_r && in_zero;
      dval_r        <= use_tw_r ? '0 : pdiff.val;
      sat_r         <= use_tw_r ? 1'b0 : pdiff.sat;
    end
    if (div_stat.done) begin
      if (state_r == aba_dcd_pkg::ST_DIV_W)
        w_r <= div_q;
      else
        wp_r <= div_q;
    end
    if ((state_r == aba_dcd_pkg::ST_MUL) && mul_stat.done) begin
      case (mop_r)
        aba_dcd_pkg::OP_EB2: begin
          eb2_r <= prod[2*V-1:0];
          s_r   <= use_tw_r ? '0 : SW'({prod[2*V-1:0], 2'b00});
        end
        aba_dcd_pkg::OP_WDF:  p1_r <= prod[PP-1:0];
        aba_dcd_pkg::OP_WPDP: begin
          dval_r <= wdiff.val;
          sat_r  <= wdiff.sat;
        end
        aba_dcd_pkg::OP_WWP: begin
          cneg_r <= cneg;
          cmag_r <= cval[F:0];
        end
        aba_dcd_pkg::OP_U2: u2_r <= prod[F+V-1:F];
        aba_dcd_pkg::OP_U1: u1_r <= prod[F+V-1:F];
        aba_dcd_pkg::OP_BT: begin
          if (!cneg_r)
            s_r <= s_r + bt_ext;
          else if (s_r >= bt_ext)
            s_r <= s_r - bt_ext;
          else
            s_r <= '0;
        end
        default: s_r <= s_r + SW'(prod[2*V-1:0]);
      endcase
    end
    if ((state_r == aba_dcd_pkg::ST_DONE) && out_free) begin
      out_data_r   <= zero_r ? '0 : {e_val, dval_r};
      out_status_r <= status_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'(out_data_r);
  assign out_tuser  = out_status_r;
  assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire

FILE: design/aba_dcd_mul.sv
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none

module aba_dcd_mul #(
  parameter int A_BITS = 64,
  parameter int B_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [A_BITS-1:0]            a,
  input  wire  [B_BITS-1:0]            b,
  output aba_dcd_pkg::unit_stat_t      stat,
  output logic [A_BITS+B_BITS-1:0]     prod
);

  localparam int PW = A_BITS + B_BITS;
  localparam int CW = $clog2(B_BITS + 1);

  logic [A_BITS-1:0] a_r;
  logic [PW-1:0]     p_r, p_nxt;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [A_BITS:0]   upper;

  // add the multiplicand into the upper half, then shift right
  always_comb begin
    upper = {1'b0, p_r[PW-1:B_BITS]} + (p_r[0] ? {1'b0, a_r} : {(A_BITS+1){1'b0}});
    p_nxt = {upper, p_r[B_BITS-1:1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(B_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{A_BITS{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign prod      = p_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

FILE: design/aba_dcd_div.sv
// restoring divider for weights: one quotient bit per cycle, clamped to one
`default_nettype none

module aba_dcd_div #(
  parameter int T_BITS = 32,
  parameter int F_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire  [T_BITS-1:0]        x,
  input  wire  [T_BITS-1:0]        d,
  output aba_dcd_pkg::unit_stat_t  stat,
  output logic [F_BITS:0]          q
);

  localparam int CW = $clog2(F_BITS + 1);
  localparam logic [F_BITS:0] ONE_W = {1'b1, {F_BITS{1'b0}}};

  logic [T_BITS-1:0] r_r, d_r, r_nxt;
  logic [F_BITS:0]   q_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [T_BITS:0]   r2, r2_sub;
  logic              ge;

  // one restoring step
  always_comb begin
    r2     = {r_r, 1'b0};
    r2_sub = r2 - {1'b0, d_r};
    ge     = (r2 >= {1'b0, d_r});
    r_nxt  = ge ? r2_sub[T_BITS-1:0] : r2[T_BITS-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (x >= d) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(F_BITS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= d;
      r_r <= x;
      q_r <= (x >= d) ? ONE_W : '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      q_r <= {q_r[F_BITS-1:0], ge};
    end
  end

  assign q         = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

FILE: design/aba_dcd_sqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
`default_nettype none

module aba_dcd_sqrt #(
  parameter int R_BITS = 34
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire  [2*R_BITS-1:0]      rad,
  output aba_dcd_pkg::unit_stat_t  stat,
  output logic [R_BITS-1:0]        root
);

  localparam int CW = $clog2(R_BITS + 1);

  logic [2*R_BITS-1:0] rad_r;
  logic [R_BITS+1:0]   rem_r, rem2, trial;
  logic [R_BITS-1:0]   root_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;
  logic                ge;

  // bring down two bits and try the next root digit
  always_comb begin
    rem2  = {rem_r[R_BITS-1:0], rad_r[2*R_BITS-1:2*R_BITS-2]};
    trial = {root_r, 2'b01};
    ge    = (rem2 >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(R_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*R_BITS-3:0], 2'b00};
      rem_r  <= ge ? (rem2 - trial) : rem2;
      root_r <= {root_r[R_BITS-2:0], ge};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

FILE: design/aba_dcd_checker.sv
// port-level checks on the result channel, bound to the top level
`default_nettype none

module aba_dcd_checker #(
  parameter int VALUE_BITS = 32,
  parameter int OUT_BITS   = 64
) (
  input wire                clk,
  input wire                rst_n,
  input wire                in_tvalid,
  input wire                in_tready,
  input wire [OUT_BITS-1:0] out_tdata,
  input wire [1:0]          out_tuser,
  input wire                out_tvalid,
  input wire                out_tready
);

  // a held result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transaction");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == aba_dcd_pkg::STATUS_OK) ||
                   (out_tuser == aba_dcd_pkg::STATUS_ZERO) ||
                   (out_tuser == aba_dcd_pkg::STATUS_SAT))
    else $error("undefined status code");

  // a zero interval gives zero difference and error
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == aba_dcd_pkg::STATUS_ZERO) |->
      (out_tdata[2*VALUE_BITS-1:0] == '0))
    else $error("zero interval result carries data");

  // reset empties the output channel and reopens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result offered or input closed after reset");

endmodule

bind aba_drift_corrected_difference aba_dcd_checker #(
  .VALUE_BITS(VALUE_BITS),
  .OUT_BITS(OUT_BITS)
) u_aba_dcd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);

`default_nettype wire

FILE: test/tb_aba_drift_corrected_difference.sv
// self-checking regression bench for the drift-corrected aba difference block
`default_nettype none

module tb_aba_drift_corrected_difference;

  localparam int TB = 32;
  localparam int VB = 32;
  localparam int FB = 16;
  localparam longint unsigned VMASK = (64'd1 << VB) - 1;
  localparam longint unsigned ONE_W = 64'd1 << FB;
  localparam int TAIL = 500;
  localparam longint unsigned CYCLE_LIMIT = 64'd6000000;

  typedef struct packed {
    logic [VB-1:0]        diff;
    logic [VB-1:0]        derr;
    aba_dcd_pkg::status_t status;
  } aba_result_t;

  typedef struct {
    logic          start;
    logic [TB-1:0] a_time;
    logic [VB-1:0] a_value;
    logic [VB-1:0] a_error;
    logic [TB-1:0] b_time;
    logic [VB-1:0] b_value;
    logic [VB-1:0] b_error;
  } trial_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [191:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [0:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  aba_drift_corrected_difference dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  // integer square root of a 128-bit value, floor
  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [127:0] res;
    logic [127:0] bitv;
    res = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0 && x < bitv) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  // q1.16 weight clamped to one
  function automatic longint unsigned calc_weight(longint unsigned x, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = x;
    if (x >= d) return ONE_W;
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // clamp a signed magnitude to the signed value range
  function automatic logic [VB-1:0] clamp_diff(bit neg, logic [127:0] m, ref bit sat);
    logic [127:0] lim;
    lim = neg ? (128'd1 << (VB - 1)) : ((128'd1 << (VB - 1)) - 1);
    if (m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? (VB'(0) - m[VB-1:0]) : m[VB-1:0];
  endfunction

  class aba_scoreboard;
    bit            weighted;
    bit            have_prev;
    trial_t        prev;
    aba_result_t   pending[$];
    int            errors;
    int            checked;

    function void clear();
      have_prev = 0;
      weighted = 0;
      prev = '{default: '0};
    endfunction

    // predict the result caused by one accepted trial
    function void note_trial(trial_t t);
      aba_result_t r;
      longint signed a1, a2, b, q, df, dp, c;
      longint unsigned ea1, ea2, eb, d, w, wp, twop, u1, u2;
      logic [127:0] s, m, p1, p2, bt, eb2, e;
      bit sat, neg;
      if (!t.start && have_prev) begin
        a1 = longint'($signed(prev.a_value));
        b = longint'($signed(prev.b_value));
        a2 = longint'($signed(t.a_value));
        ea1 = prev.a_error;
        ea2 = t.a_error;
        eb = prev.b_error;
        eb2 = 128'(eb) * 128'(eb);
        sat = 0;
        r.status = aba_dcd_pkg::STATUS_OK;
        r.diff = '0;
        r.derr = '0;
        e = '0;
        if (!weighted) begin
          q = (a1 + a2 - 2 * b) / 2;
          m = 128'(q < 0 ? -q : q);
          r.diff = clamp_diff(q < 0, m, sat);
          s = eb2 * 4 + 128'(ea2) * 128'(ea2) + 128'(ea1) * 128'(ea1);
          e = 128'(isqrt128(s) >> 1);
        end else begin
          d = (t.a_time >= prev.a_time) ? t.a_time - prev.a_time : prev.a_time - t.a_time;
          if (d == 0) begin
            r.status = aba_dcd_pkg::STATUS_ZERO;
          end else begin
            w = calc_weight(prev.a_time >= prev.b_time ? prev.a_time - prev.b_time
                            : prev.b_time - prev.a_time, d);
            wp = calc_weight(t.a_time >= prev.b_time ? t.a_time - prev.b_time
                             : prev.b_time - t.a_time, d);
            df = a2 - b;
            dp = a1 - b;
            p1 = 128'(w) * 128'(df < 0 ? -df : df);
            p2 = 128'(wp) * 128'(dp < 0 ? -dp : dp);
            if ((df < 0) == (dp < 0)) begin
              m = p1 + p2;
              neg = df < 0;
            end else if (p1 >= p2) begin
              m = p1 - p2;
              neg = df < 0;
            end else begin
              m = p2 - p1;
              neg = dp < 0;
            end
            r.diff = clamp_diff(neg, m >> FB, sat);
            twop = (2 * w * wp) >> FB;
            c = longint'(ONE_W) - longint'(twop);
            u2 = 64'((128'(w) * 128'(ea2)) >> FB);
            u1 = 64'((128'(wp) * 128'(ea1)) >> FB);
            s = 128'(u2) * 128'(u2) + 128'(u1) * 128'(u1);
            bt = (eb2 * 128'(c < 0 ? -c : c)) >> FB;
            if (c >= 0) s = s + bt;
            else if (s >= bt) s = s - bt;
            else s = '0;
            e = 128'(isqrt128(s));
          end
        end
        if (r.status == aba_dcd_pkg::STATUS_OK) begin
          if (e > 128'(VMASK)) begin
            e = 128'(VMASK);
            sat = 1;
          end
          r.derr = e[VB-1:0];
          if (sat) r.status = aba_dcd_pkg::STATUS_SAT;
        end
        pending.insert(pending.size(), r);
      end
      prev = t;
      have_prev = 1;
    endfunction

    function void check_result(aba_result_t got);
      aba_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result diff=%h err=%h status=%0d", $realtime,
                 got.diff, got.derr, got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.diff !== exp_r.diff) begin
        $display("%0t: difference mismatch expected %h actual %h", $realtime,
                 exp_r.diff, got.diff);
        errors++;
      end
      if (got.derr !== exp_r.derr) begin
        $display("%0t: difference_error mismatch expected %h actual %h", $realtime,
                 exp_r.derr, got.derr);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                 exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  aba_scoreboard sb;
  longint unsigned cycles = 0;
  bit long_hold = 0;
  int n_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("aba_drift_corrected_difference regression: fail");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{diff: out_tdata[31:0], derr: out_tdata[63:32],
                        status: aba_dcd_pkg::status_t'(out_tuser)});
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        long_hold = 0;
      end
      hold = $urandom_range(0, 7);
      if (hold < 5) out_tready <= 1'b1;
      else out_tready <= 1'b0;
    end
  end

  task automatic send_trial(trial_t t);
    in_tdata <= {t.b_error, t.b_value, t.b_time, t.a_error, t.a_value, t.a_time};
    in_tuser <= t.start;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_trial(t);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_line();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    idle_line();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  task automatic write_mode(bit mode);
    drain();
    cfg_data <= mode;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.weighted = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_edge32();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // random trial; mostly a series with nearby times and modest values
  function automatic trial_t rand_trial(logic [31:0] base);
    trial_t t;
    int k;
    k = $urandom_range(0, 9);
    t.start = ($urandom_range(0, 11) == 0);
    if (k < 7) begin
      t.a_time = base + $urandom_range(0, 2000);
      t.b_time = t.a_time - $urandom_range(0, 1500) + $urandom_range(0, 1500);
      t.a_value = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      t.b_value = t.a_value + $urandom_range(0, 65535) - 32768;
      t.a_error = $urandom_range(0, 32'h000F_FFFF);
      t.b_error = $urandom_range(0, 32'h000F_FFFF);
      if ($urandom_range(0, 20) == 0) t.a_time = base;
    end else begin
      t.a_time = rand_edge32();
      t.b_time = rand_edge32();
      t.a_value = rand_edge32();
      t.b_value = rand_edge32();
      t.a_error = rand_edge32();
      t.b_error = rand_edge32();
    end
    return t;
  endfunction

  task automatic random_phase(int count);
    logic [31:0] base;
    trial_t t;
    int burst;
    base = $urandom;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) begin
        idle_line();
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
      for (int i = 0; i < burst && count > 0; i++) begin
        t = rand_trial(base);
        base = t.a_time;
        send_trial(t);
        count--;
      end
    end
  endtask

  initial begin
    trial_t t;
    sb = new();
    sb.clear();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: both modes with extremes and saturation
    for (int mode = 0; mode < 2; mode++) begin
      write_mode(mode[0]);
      t = '{1'b1, 32'd100, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd150, 32'h8000_0000, 32'hFFFF_FFFF};
      send_trial(t);
      t = '{1'b0, 32'd200, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h0, 32'h0};
      send_trial(t);
      // zero interval
      t = '{1'b0, 32'd200, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF};
      send_trial(t);
      // reversed a times, b outside the interval
      t = '{1'b0, 32'd50, 32'h0001_0000, 32'h0001_0000, 32'd60, 32'hFFFF_0000, 32'h0002_0000};
      send_trial(t);
      t = '{1'b0, 32'd70, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
      send_trial(t);
      t = '{1'b0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'd0, 32'h1, 32'h1};
      send_trial(t);
      t = '{1'b0, 32'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0};
      send_trial(t);
      // fresh series start drops the stored trial
      t = '{1'b1, 32'd10, 32'h1234_5678, 32'h100, 32'd15, 32'h0123_4567, 32'h200};
      send_trial(t);
      t = '{1'b0, 32'd20, 32'h1234_0000, 32'h100, 32'd25, 32'h0, 32'h0};
      send_trial(t);
    end

    // random phases across both settings, the register ends in time-weighted mode
    write_mode(1'b0);
    random_phase(400);
    write_mode(1'b1);
    random_phase(400);
    // long receiver hold-off while the sender keeps offering
    long_hold = 1;
    random_phase(50);
    // sender pause until all results are in
    drain();
    random_phase(400);
    write_mode(1'b0);
    random_phase(400);
    write_mode(1'b1);
    random_phase(60);

    drain();
    $display("sent %0d trials, checked %0d results over plain and time-weighted modes",
             n_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("aba_drift_corrected_difference regression: pass");
    end else begin
      $display("aba_drift_corrected_difference regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
